FILE: rtl/core/mdf_pkg.sv
// Package for the median deadband distance filter: widths, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package mdf_pkg;

   localparam int WINDOW_LEN_DEF = 5;

   localparam int DIST_W   = 16;
   localparam int OFFSET_W = 10;
   localparam int HOLD_W   = 8;
   localparam int FAST_W   = 10;
   localparam int CSR_W    = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(0);
   localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(3);
   localparam logic [FAST_W-1:0]   FAST_RST   = FAST_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFFSET = 2'd0,
      REG_HOLD   = 2'd1,
      REG_FAST   = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIFF,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic diff;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } status_type;

endpackage

FILE: rtl/core/mdf_if.sv
// Handshake interfaces for the sample channel and the result channel.
// Depends on mdf_pkg.
interface mdf_req_if import mdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] raw_distance_cm;
   logic              restart;

   modport source (output valid, raw_distance_cm, restart, input ready);
   modport sink   (input valid, raw_distance_cm, restart, output ready);
endinterface

interface mdf_rsp_if import mdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] median_cm;
   logic [DIST_W-1:0] display_cm;

   modport source (output valid, median_cm, display_cm, input ready);
   modport sink   (input valid, median_cm, display_cm, output ready);
endinterface

FILE: rtl/core/mdf_ctrl.sv
// Controller state machine: accept, rank scan, difference, display update.
// Depends on mdf_pkg.
module mdf_ctrl import mdf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output register is free
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.diff   = (state_ff == ST_DIFF);
      cmd.update = (state_ff == ST_UPDATE) && !status.out_busy;
   end

endmodule

FILE: rtl/core/mdf_dpath.sv
// Datapath: config registers, sample ring, rank-based median scan, display
// smoother and output register. Depends on mdf_pkg.
module mdf_dpath import mdf_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [DIST_W-1:0]    req_raw_distance_cm,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DIST_W-1:0]    rsp_median_cm,
   output logic [DIST_W-1:0]    rsp_display_cm,
   input  cmd_type              cmd,
   output status_type           status
);

   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LEN);

   logic [OFFSET_W-1:0] offset_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic [FAST_W-1:0]   fast_ff;

   logic [DIST_W-1:0] ring_ff [WINDOW_LEN];
   logic [IDX_W-1:0]  slot_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              tracking_ff;
   logic [DIST_W-1:0] shown_ff;
   logic [DIST_W-1:0] median_ff;
   logic signed [DIST_W:0] diff_ff;
   logic [DIST_W-1:0] mag_ff;
   logic              out_valid_ff;
   logic [DIST_W-1:0] out_median_ff;
   logic [DIST_W-1:0] out_display_ff;

   logic [DIST_W-1:0] sample;
   logic [IDX_W-1:0]  slot_base;
   logic [DIST_W-1:0] cand;
   logic [CNT_W-1:0]  rank;
   logic              cand_valid;
   logic signed [DIST_W:0] step_half, step_quarter, step;
   logic [DIST_W:0]   shown_sum;
   logic [DIST_W-1:0] shown_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RST;
         hold_ff   <= HOLD_RST;
         fast_ff   <= FAST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            REG_HOLD:   hold_ff   <= csr_wdata[HOLD_W-1:0];
            REG_FAST:   fast_ff   <= csr_wdata[FAST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // offset correction floored at zero
   always_comb begin
      if (req_raw_distance_cm > DIST_W'(offset_ff)) begin
         sample = req_raw_distance_cm - DIST_W'(offset_ff);
      end else begin
         sample = '0;
      end
      slot_base = req_restart ? '0 : slot_ff;
   end

   // rank of the candidate: smaller entries plus equal entries at lower slots
   always_comb begin
      cand = ring_ff[idx_ff];
      rank = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if ((CNT_W'(j) < fill_ff) &&
             ((ring_ff[j] < cand) || ((ring_ff[j] == cand) && (IDX_W'(j) < idx_ff)))) begin
            rank = rank + CNT_W'(1);
         end
      end
      cand_valid = (CNT_W'(idx_ff) < fill_ff);
   end

   // display step, division truncating toward zero
   always_comb begin
      step_half    = $signed(diff_ff + (DIST_W+1)'(diff_ff[DIST_W])) >>> 1;
      step_quarter = $signed(diff_ff + (diff_ff[DIST_W] ? (DIST_W+1)'(3) : '0)) >>> 2;
      if (mag_ff <= DIST_W'(hold_ff)) begin
         step = '0;
      end else if (mag_ff >= DIST_W'(fast_ff)) begin
         step = step_half;
      end else begin
         step = step_quarter;
      end
      shown_sum = {1'b0, shown_ff} + step;
      shown_in  = tracking_ff ? shown_sum[DIST_W-1:0] : median_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         tracking_ff <= 1'b0;
         shown_ff    <= '0;
         idx_ff      <= '0;
      end else begin
         if (cmd.load) begin
            slot_ff <= (slot_base == LAST_IDX) ? '0 : slot_base + IDX_W'(1);
            if (req_restart) begin
               fill_ff     <= CNT_W'(1);
               tracking_ff <= 1'b0;
            end else if (fill_ff != FULL_CNT) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
            idx_ff <= '0;
         end
         // hold at the last slot so the candidate stays inside the ring
         if (cmd.scan && !status.scan_last) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.update) begin
            shown_ff    <= shown_in;
            tracking_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ring_ff[slot_base] <= sample;
      end
      if (cmd.scan && cand_valid && (rank == (fill_ff >> 1))) begin
         median_ff <= cand;
      end
      if (cmd.diff) begin
         diff_ff <= $signed({1'b0, median_ff}) - $signed({1'b0, shown_ff});
         mag_ff  <= (median_ff >= shown_ff) ? median_ff - shown_ff : shown_ff - median_ff;
      end
      if (cmd.update) begin
         out_median_ff  <= median_ff;
         out_display_ff <= shown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.scan_last = (idx_ff == LAST_IDX);
   assign status.out_busy  = out_valid_ff && !rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_median_cm  = out_median_ff;
   assign rsp_display_cm = out_display_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT) else $error("fill count above window length");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_IDX) else $error("write slot outside ring");

   a_update_free: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !(out_valid_ff && !rsp_ready))
      else $error("update would overwrite a waiting result");

   a_update_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (out_valid_ff && tracking_ff))
      else $error("update did not present a result");

   a_load_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (fill_ff != '0)) else $error("window empty after a sample");

endmodule

FILE: rtl/core/median_deadband_distance_filter.sv
// Median deadband distance filter, top level. An accepted item passes the rank
// scan, which tests one ring entry per cycle, then the difference and update
// steps before its result is valid. A new item is accepted only once the last one
// has left the update step; a stalled result holds the next item in the update
// step. Reset (synchronous, active high) restores the register defaults and
// empties the window. Depends on mdf_pkg, mdf_if, mdf_ctrl and mdf_dpath.
module median_deadband_distance_filter import mdf_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   mdf_req_if.sink              req_ch,
   mdf_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mdf_dpath #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_raw_distance_cm (req_ch.raw_distance_cm),
      .req_restart         (req_ch.restart),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_median_cm       (rsp_ch.median_cm),
      .rsp_display_cm      (rsp_ch.display_cm),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule
